@@ hdl/tccs_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and word types for the text console cursor and scroll engine
// no dependencies

package tccs_pkg;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELL_COUNT   = ROWS * COLUMNS;
    localparam int SCROLL_COUNT = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W       = $clog2(CELL_COUNT);
    localparam int CNT_W        = $clog2(CELL_COUNT + 1);

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_column;
    } req_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic              scrolled;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic valid;
        rsp_t data;
    } res_t;

endpackage

@@ hdl/tccs_ram.sv @@
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// no dependencies

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/tccs_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer for the console: cursor state, screen fill, scroll copy and cell access
// depends on tccs_pkg; drives the screen ram through a ram_req_t word

module tccs_ctrl import tccs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    input  logic [ATTR_W-1:0] text_attribute,
    input  logic              slot_free,
    output res_t              res,
    output ram_req_t          ram,
    input  logic [CELL_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_PUT,
        S_FILL,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              scrolled_reg, scrolled_next;
    logic              hit_reg, hit_next;

    logic [ROW_W-1:0]  row_inc;
    logic [ROW_W-1:0]  wrap_row;
    logic [COL_W-1:0]  wrap_col;
    logic [CELL_W-1:0] blank;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    assign blank     = {text_attribute, CHAR_W'(0)};
    assign row_inc   = (row_reg < ROW_W'(ROWS)) ? row_reg + ROW_W'(1) : row_reg;
    // a pending wrap moves to column 0 of the next row first
    assign wrap_row  = (col_reg >= COL_W'(COLUMNS)) ? row_inc : row_reg;
    assign wrap_col  = (col_reg >= COL_W'(COLUMNS)) ? COL_W'(0) : col_reg;
    assign req_ready = (state_reg == S_IDLE);

    assign res.valid = (state_reg == S_DONE);
    assign res.data  = '{cell_value: cell_reg, cursor_row: row_reg,
                         cursor_column: col_reg, scrolled: scrolled_reg};

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cnt_next      = cnt_reg;
        char_next     = char_reg;
        cell_next     = cell_reg;
        scrolled_next = scrolled_reg;
        hit_next      = hit_reg;
        ram.we        = 1'b0;
        ram.waddr     = '0;
        ram.wdata     = '0;
        ram.raddr     = cell_addr(req.read_row, req.read_column);

        unique case (state_reg)
            S_INIT:
            begin
                ram.we    = 1'b1;
                ram.waddr = cnt_reg[ADDR_W-1:0];
                ram.wdata = {RESET_ATTR, CHAR_W'(0)};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cell_next     = '0;
                    scrolled_next = 1'b0;
                    char_next     = req.char_code;
                    cnt_next      = '0;
                    unique case (req.cmd)
                        CMD_PUT:
                        begin
                            if (req.char_code == CH_NEWLINE)
                            begin
                                col_next   = '0;
                                row_next   = row_inc;
                                state_next = S_DONE;
                            end
                            else if (req.char_code == CH_RETURN)
                            begin
                                col_next   = '0;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                col_next = wrap_col;
                                row_next = wrap_row;
                                if (wrap_row >= ROW_W'(ROWS))
                                begin
                                    scrolled_next = 1'b1;
                                    state_next    = S_SCROLL;
                                end
                                else
                                begin
                                    state_next = S_PUT;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            state_next = S_FILL;
                        end
                        CMD_READ:
                        begin
                            hit_next   = (req.read_row < ROW_W'(ROWS)) &&
                                         (req.read_column < COL_W'(COLUMNS));
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cell_next  = hit_reg ? ram_rdata : '0;
                state_next = S_DONE;
            end
            S_SCROLL:
            begin
                // read runs one row ahead, the write of each cell follows in the cycle after its read
                if (cnt_reg < CNT_W'(SCROLL_COUNT))
                begin
                    ram.raddr = ADDR_W'(cnt_reg + CNT_W'(COLUMNS));
                end
                if (cnt_reg != '0)
                begin
                    ram.we    = 1'b1;
                    ram.waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                    ram.wdata = (cnt_reg <= CNT_W'(SCROLL_COUNT)) ? ram_rdata : blank;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELL_COUNT))
                begin
                    cnt_next   = '0;
                    row_next   = ROW_W'(ROWS - 1);
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                ram.we     = 1'b1;
                ram.waddr  = cell_addr(row_reg, col_reg);
                ram.wdata  = {text_attribute, char_reg};
                cell_next  = {text_attribute, char_reg};
                col_next   = col_reg + COL_W'(1);
                state_next = S_DONE;
            end
            S_FILL:
            begin
                ram.we    = 1'b1;
                ram.waddr = cnt_reg[ADDR_W-1:0];
                ram.wdata = blank;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            row_reg      <= '0;
            col_reg      <= '0;
            cnt_reg      <= '0;
            char_reg     <= '0;
            cell_reg     <= '0;
            scrolled_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            cnt_reg      <= cnt_next;
            char_reg     <= char_next;
            cell_reg     <= cell_next;
            scrolled_reg <= scrolled_next;
            hit_reg      <= hit_next;
        end
    end

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (row_reg <= ROW_W'(ROWS)) && (col_reg <= COL_W'(COLUMNS)))
        else $error("cursor out of range on result");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram.we |-> ram.waddr < ADDR_W'(CELL_COUNT))
        else $error("screen write outside the cell array");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.scrolled |-> row_reg == ROW_W'(ROWS - 1))
        else $error("scrolled result not on the last row");

    a_put_path: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.cmd == CMD_PUT &&
        req.char_code != CH_NEWLINE && req.char_code != CH_RETURN
        |=> state_reg == S_PUT || state_reg == S_SCROLL)
        else $error("ordinary character did not go to a cell write");

endmodule

@@ hdl/text_console_cursor_scroll_top.sv @@
`timescale 1ns / 1ps
// top level of the text console engine: attribute register, result register, screen ram
// depends on tccs_pkg, tccs_ram and tccs_ctrl
//
//  channel | direction | word                       | handshake
//  req     | in        | req_t: cmd, char, read pos | req_valid / req_ready
//  rsp     | out       | rsp_t: cell, cursor, flag  | rsp_valid / rsp_ready
//  cfg     | in        | text_attribute byte        | cfg_valid / cfg_ready (always ready)
//
// newline, return and unused commands go straight from idle to the result state
// put passes through a cell write state and read through a ram read state before the result
// a put that scrolls first runs a copy pass: one screen ram copy or blank per cycle
// clear: a fill pass, one cell per cycle, then the result
// after reset an init pass sets every cell to 0x0F00 with req_ready low
// one result register; the next word is accepted while a result waits on rsp_ready

module text_console_cursor_scroll_top import tccs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ATTR_W-1:0] cfg_data
);

    logic [ATTR_W-1:0] attr_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    logic              slot_free;
    res_t              res;
    ram_req_t          ram;
    logic [CELL_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    tccs_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .text_attribute (attr_reg),
        .slot_free      (slot_free),
        .res            (res),
        .ram            (ram),
        .ram_rdata      (ram_rdata)
    );

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .raddr (ram.raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= RESET_ATTR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
            if (res.valid && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && slot_free)
        begin
            rsp_reg <= res.data;
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for text_console_cursor_scroll_top: directed table, then random segments
// depends on tccs_pkg and the top level; prediction comes from an in-bench console model

module tb_top;
    import tccs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int GAP_MAX = 13;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 50;
    localparam int TIMEOUT_CYCLES = 20_000_000;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    req_t              req;
    logic              rsp_valid;
    logic              rsp_ready;
    rsp_t              rsp;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ATTR_W-1:0] cfg_data;

    text_console_cursor_scroll_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // console model state
    logic [CELL_W-1:0] screen_model [0:CELL_COUNT-1];
    int                cur_row;
    int                cur_col;
    logic [ATTR_W-1:0] attr_byte;

    rsp_t cursor_reports [$];

    typedef struct packed {
        req_t w;
        logic typed;
        rsp_t want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    int mismatch_count;
    int words_sent;
    int hold_off_cycles;
    int tx_run_left;
    bit tx_quiet;
    int rx_run_left;
    bit rx_quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_t console_step(input req_t w);
        rsp_t              r;
        logic [CELL_W-1:0] blank;
        int                i;
        r = '0;
        blank = {attr_byte, 8'h00};
        case (w.cmd)
            CMD_PUT:
            begin
                if (w.char_code == CH_NEWLINE)
                begin
                    cur_col = 0;
                    if (cur_row < ROWS)
                        cur_row++;
                end
                else if (w.char_code == CH_RETURN)
                begin
                    cur_col = 0;
                end
                else
                begin
                    // pending wrap first, then a pending scroll
                    if (cur_col >= COLUMNS)
                    begin
                        cur_col = 0;
                        if (cur_row < ROWS)
                            cur_row++;
                    end
                    if (cur_row >= ROWS)
                    begin
                        for (i = 0; i < SCROLL_COUNT; i++)
                            screen_model[i] = screen_model[i + COLUMNS];
                        for (i = SCROLL_COUNT; i < CELL_COUNT; i++)
                            screen_model[i] = blank;
                        cur_row = ROWS - 1;
                        r.scrolled = 1'b1;
                    end
                    r.cell_value = {attr_byte, w.char_code};
                    screen_model[cur_row * COLUMNS + cur_col] = r.cell_value;
                    cur_col++;
                end
            end
            CMD_CLEAR:
            begin
                for (i = 0; i < CELL_COUNT; i++)
                    screen_model[i] = blank;
                cur_row = 0;
                cur_col = 0;
            end
            CMD_READ:
            begin
                if (w.read_row < ROWS && w.read_column < COLUMNS)
                    r.cell_value = screen_model[int'(w.read_row) * COLUMNS
                                                + int'(w.read_column)];
            end
            default:
            begin
            end
        endcase
        r.cursor_row = 5'(cur_row);
        r.cursor_column = 7'(cur_col);
        return r;
    endfunction

    // idle stretches alternate with runs of back-to-back words
    function automatic int next_gap(inout int run_left, inout bit quiet);
        if (run_left == 0)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(10, 60);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic req_t rand_req();
        req_t w;
        w.cmd = 2'($urandom_range(0, 3));
        w.char_code = 8'($urandom_range(0, 255));
        w.read_row = 5'($urandom_range(0, 31));
        w.read_column = 7'($urandom_range(0, 127));
        return w;
    endfunction

    function automatic req_t put_word(input logic [CHAR_W-1:0] ch);
        req_t w;
        w = rand_req();
        w.cmd = CMD_PUT;
        w.char_code = ch;
        return w;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] c, input logic [CHAR_W-1:0] ch,
                                    input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                                    input logic typed, input logic [CELL_W-1:0] cell_want,
                                    input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        dir_row_t d;
        d.w.cmd = c;
        d.w.char_code = ch;
        d.w.read_row = rr;
        d.w.read_column = rc;
        d.typed = typed;
        d.want.cell_value = cell_want;
        d.want.cursor_row = row;
        d.want.cursor_column = col;
        d.want.scrolled = 1'b0;
        dir_rows.push_back(d);
    endfunction

    function automatic void check_report(input rsp_t got);
        rsp_t want;
        if (cursor_reports.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected word, expected none actual %h", $time, got);
            return;
        end
        want = cursor_reports.pop_front();
        if (got !== want)
        begin
            mismatch_count++;
            if (got.cell_value !== want.cell_value)
                $display("%0t: cell_value expected %h actual %h",
                         $time, want.cell_value, got.cell_value);
            if (got.cursor_row !== want.cursor_row)
                $display("%0t: cursor_row expected %0d actual %0d",
                         $time, want.cursor_row, got.cursor_row);
            if (got.cursor_column !== want.cursor_column)
                $display("%0t: cursor_column expected %0d actual %0d",
                         $time, want.cursor_column, got.cursor_column);
            if (got.scrolled !== want.scrolled)
                $display("%0t: scrolled expected %b actual %b",
                         $time, want.scrolled, got.scrolled);
        end
    endfunction

    task automatic offer_word(input req_t w);
        int gap;
        gap = next_gap(tx_run_left, tx_quiet);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (!req_ready);
        words_sent++;
    endtask

    task automatic send_word(input req_t w);
        offer_word(w);
        cursor_reports.push_back(console_step(w));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (cursor_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        attr_byte = v;
    endtask

    task automatic emit_segment();
        int   kind;
        int   n;
        int   i;
        int   row;
        req_t w;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            // a line of text, often long enough to wrap
            n = $urandom_range(1, 90);
            for (i = 0; i < n; i++)
                send_word(put_word(8'($urandom_range(0, 255))));
            if ($urandom_range(0, 1) == 1)
                send_word(put_word(CH_NEWLINE));
        end
        else if (kind < 45)
        begin
            n = $urandom_range(1, 30);
            for (i = 0; i < n; i++)
                send_word(put_word(CH_NEWLINE));
        end
        else if (kind < 75)
        begin
            n = $urandom_range(1, 10);
            for (i = 0; i < n; i++)
            begin
                w = rand_req();
                w.cmd = CMD_READ;
                case ($urandom_range(0, 5))
                    0, 1, 2:
                    begin
                        // near the cursor, where the text just went
                        row = (cur_row >= ROWS) ? ROWS - 1 : cur_row;
                        w.read_row = 5'(row);
                        w.read_column = 7'($urandom_range(0, COLUMNS - 1));
                    end
                    3, 4:
                    begin
                        w.read_row = 5'($urandom_range(0, ROWS - 1));
                        w.read_column = 7'($urandom_range(0, COLUMNS - 1));
                    end
                    default:
                    begin
                    end
                endcase
                send_word(w);
            end
        end
        else if (kind < 80)
        begin
            send_word(put_word(CH_RETURN));
            n = $urandom_range(1, 20);
            for (i = 0; i < n; i++)
                send_word(put_word(8'($urandom_range(0, 255))));
        end
        else if (kind < 83)
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
            begin
                w = rand_req();
                w.cmd = CMD_NONE;
                send_word(w);
            end
        end
        else if (kind < 85)
        begin
            w = rand_req();
            w.cmd = CMD_CLEAR;
            send_word(w);
        end
        else
        begin
            // noise; clears are slow so they stay in the clear segment
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++)
            begin
                w = rand_req();
                if (w.cmd == CMD_CLEAR)
                    w.cmd = CMD_READ;
                send_word(w);
            end
        end
    endtask

    task automatic run_phase(input int quota);
        int base;
        base = words_sent;
        while (words_sent - base < quota)
            emit_segment();
    endtask

    initial
    begin : receiver
        rsp_ready = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            if (next_gap(rx_run_left, rx_quiet) > 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            check_report(rsp);
        end
    end

    initial
    begin : driver
        int   i;
        rsp_t r;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatch_count = 0;
        words_sent = 0;
        hold_off_cycles = 0;
        tx_run_left = 0;
        rx_run_left = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        attr_byte = RESET_ATTR;
        cur_row = 0;
        cur_col = 0;
        for (i = 0; i < CELL_COUNT; i++)
            screen_model[i] = {RESET_ATTR, 8'h00};

        // cmd, char, read row, read col, typed, cell, row, col
        add_row(CMD_READ,  8'h5A,      5'd0,  7'd0,   1'b1, 16'h0F00, 5'd0, 7'd0);
        add_row(CMD_READ,  8'h00,      5'd24, 7'd79,  1'b1, 16'h0F00, 5'd0, 7'd0);
        add_row(CMD_READ,  8'hFF,      5'd31, 7'd127, 1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(CMD_READ,  8'h00,      5'd25, 7'd0,   1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(CMD_READ,  8'h00,      5'd0,  7'd80,  1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(CMD_PUT,   8'h41,      5'd0,  7'd0,   1'b1, 16'h0F41, 5'd0, 7'd1);
        add_row(CMD_PUT,   8'h00,      5'd0,  7'd0,   1'b1, 16'h0F00, 5'd0, 7'd2);
        add_row(CMD_PUT,   8'hFF,      5'd0,  7'd0,   1'b1, 16'h0FFF, 5'd0, 7'd3);
        add_row(CMD_PUT,   CH_RETURN,  5'd0,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(CMD_PUT,   CH_NEWLINE, 5'd0,  7'd0,   1'b1, 16'h0000, 5'd1, 7'd0);
        add_row(CMD_READ,  8'h00,      5'd0,  7'd0,   1'b1, 16'h0F41, 5'd1, 7'd0);
        add_row(CMD_READ,  8'h00,      5'd0,  7'd2,   1'b1, 16'h0FFF, 5'd1, 7'd0);
        add_row(CMD_NONE,  8'h00,      5'd0,  7'd0,   1'b1, 16'h0000, 5'd1, 7'd0);
        add_row(CMD_NONE,  8'hFF,      5'd31, 7'd127, 1'b1, 16'h0000, 5'd1, 7'd0);
        add_row(CMD_PUT,   8'h7E,      5'd31, 7'd127, 1'b1, 16'h0F7E, 5'd1, 7'd1);
        add_row(CMD_READ,  8'hFF,      5'd1,  7'd0,   1'b1, 16'h0F7E, 5'd1, 7'd1);
        add_row(CMD_CLEAR, 8'hFF,      5'd31, 7'd127, 1'b1, 16'h0000, 5'd0, 7'd0);
        add_row(CMD_READ,  8'h00,      5'd1,  7'd0,   1'b1, 16'h0F00, 5'd0, 7'd0);
        add_row(CMD_PUT,   8'h80,      5'd17, 7'd42,  1'b0, '0, '0, '0);
        add_row(CMD_PUT,   8'h55,      5'd0,  7'd0,   1'b0, '0, '0, '0);
        add_row(CMD_PUT,   CH_RETURN,  5'd31, 7'd127, 1'b0, '0, '0, '0);
        add_row(CMD_PUT,   8'hAA,      5'd0,  7'd0,   1'b0, '0, '0, '0);
        add_row(CMD_READ,  8'h00,      5'd0,  7'd0,   1'b0, '0, '0, '0);
        add_row(CMD_READ,  8'h00,      5'd0,  7'd1,   1'b0, '0, '0, '0);
        add_row(CMD_PUT,   CH_NEWLINE, 5'd0,  7'd0,   1'b0, '0, '0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            offer_word(dir_rows[i].w);
            r = console_step(dir_rows[i].w);
            cursor_reports.push_back(dir_rows[i].typed ? dir_rows[i].want : r);
        end

        write_attr(8'h00);
        run_phase(488);

        // receiver stalls for a long stretch while words keep coming
        write_attr(8'hFF);
        run_phase(240);
        hold_off_cycles = HOLD_CYCLES;
        run_phase(248);

        // sender waits for every pending result once, between the two runs
        write_attr(8'($urandom_range(0, 255)));
        run_phase(240);
        wait_drained();
        run_phase(248);

        write_attr(8'($urandom_range(0, 255)));
        run_phase(488);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

endmodule
